### src/sthd_pkg.sv
// ----------------------------------------------------------------------------
// sthd_pkg: shared types and constants of the scheduled thermostat drive
// command and status codes, sequencer states, schedule entry layout and
// the time compare used by the table lookup and the sort pass
// ----------------------------------------------------------------------------
package sthd_pkg;

  // default schedule depth
  localparam int MAX_ENTRIES_DEF = 16;

  // temperature and time limits
  localparam logic [8:0] TEMP_MAX   = 9'd500;
  localparam logic [8:0] SP_RESET   = 9'd250;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // burst cycle constants
  localparam int         ERR_LIMIT  = 15;
  localparam logic [4:0] ON_EXTRA   = 5'd4;
  localparam logic [4:0] BURST_SPAN = 5'd16;

  // request kinds
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SAMPLE = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_EDIT   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // one schedule entry as held in the table memory
  typedef struct packed {
    logic [8:0] temp;
    logic [5:0] minute;
    logic [4:0] hour;
  } entry_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SAMPLE_FIN,
    S_IDX_RD,
    S_IDX_WAIT,
    S_DEL_RD,
    S_DEL_WR,
    S_SORT_LD,
    S_SORT_LDW,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_END,
    S_DONE
  } state_t;

  // true when time a is strictly later than time b
  function automatic logic later_than(logic [4:0] ah, logic [5:0] am,
                                      logic [4:0] bh, logic [5:0] bm);
    later_than = (ah > bh) || ((ah == bh) && (am > bm));
  endfunction

endpackage

### src/sthd_ram.sv
// ----------------------------------------------------------------------------
// sthd_ram: generic single write port, single read port memory
// one write and one registered read per cycle, no reset of contents
// ----------------------------------------------------------------------------
module sthd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/scheduled_thermostat_drive.sv
// ----------------------------------------------------------------------------
// scheduled_thermostat_drive: time-scheduled heater controller
// sorted schedule table in a small memory, walked one entry at a time by a
// sequencer around a single time comparator; tick-driven burst drive
// ----------------------------------------------------------------------------
// channel   | direction | handshake              | content
// in_       | slave     | tvalid/tready          | tuser cmd, tdata entry/sample
// out_      | master    | tvalid/tready          | tdata drive, setpoint, status
// cfg_      | apb slave | psel/penable/pready    | manual_setpoint at 0x0
//
// a request is worked through to its result before the next is taken; the
// table memory is read one entry at a time (address then registered data)
// through the shared time comparator.
// reset (rst_n low, synchronous) empties the table and clears the drive;
// table contents are not cleared. a stalled result holds in the output
// register while the next request is already taken and worked on.
// ----------------------------------------------------------------------------
module scheduled_thermostat_drive #(
  parameter int MAX_ENTRIES = sthd_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // sensor_reading[9:0], hour_now[14:10], minute_now[20:15],
  // entry_temperature[29:21], entry_index[34:30]
  input  logic [39:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // heater_on[0], setpoint[9:1], active_entry[13:10], entry_count[18:14],
  // status[20:19]
  output logic [23:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import sthd_pkg::*;

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  // sequencer and control state
  state_t          st_r, st_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   ix_r, ix_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [8:0]      cur_sp_r, cur_sp_nxt;
  logic [IW-1:0]   cur_entry_r, cur_entry_nxt;
  logic [3:0]      last_err_r, last_err_nxt;
  logic            burst_en_r, burst_en_nxt;
  logic            cyc_run_r, cyc_run_nxt;
  logic [4:0]      on_left_r, on_left_nxt;
  logic [4:0]      off_left_r, off_left_nxt;
  logic            drive_r, drive_nxt;
  logic            out_v_r, out_v_nxt;
  logic [23:0]     out_data_r, out_data_nxt;
  logic [8:0]      manual_r;

  // datapath registers
  entry_t          carry_r, carry_nxt;
  entry_t          hold_r, hold_nxt;
  logic [2:0]      cmd_r;
  logic [9:0]      rd_r;
  logic [4:0]      hr_r;
  logic [5:0]      mn_r;
  logic [8:0]      tp_r;
  logic [4:0]      idx_r;

  // table memory port
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [IW-1:0]   ram_raddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;

  logic            in_fire;
  logic            cfg_wr;
  entry_t          new_entry;
  logic            entry_later;
  logic [CMPW-1:0] idx_c;
  logic [CMPW-1:0] cnt_c;
  logic [10:0]     diff;
  logic [4:0]      on_v;
  logic [4:0]      off_v;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {23'd0, manual_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_r <= SP_RESET;
    end else if (cfg_wr) begin
      manual_r <= cfg_pwdata[8:0];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_tuser;
      rd_r  <= in_tdata[9:0];
      hr_r  <= in_tdata[14:10];
      mn_r  <= in_tdata[20:15];
      tp_r  <= in_tdata[29:21];
      idx_r <= in_tdata[34:30];
    end
  end

  // clamped entry for insert and edit; first entry always starts at midnight
  always_comb begin
    new_entry.temp   = (tp_r > TEMP_MAX) ? 9'd0 : tp_r;
    new_entry.hour   = ((hr_r > HOUR_MAX) || (cnt_r == '0)) ? 5'd0 : hr_r;
    new_entry.minute = ((mn_r > MINUTE_MAX) || (cnt_r == '0)) ? 6'd0 : mn_r;
  end

  // shared comparator: memory entry against either the time now or the carry
  always_comb begin
    if (st_r == S_SCAN_CMP) begin
      entry_later = later_than(ram_rdata.hour, ram_rdata.minute, hr_r, mn_r);
    end else begin
      entry_later = later_than(ram_rdata.hour, ram_rdata.minute,
                               carry_r.hour, carry_r.minute);
    end
  end

  assign idx_c = CMPW'(idx_r);
  assign cnt_c = CMPW'(cnt_r);
  assign diff  = {2'b00, cur_sp_r} - {1'b0, rd_r};

  // schedule table
  sthd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: next state, datapath updates and memory control
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    ix_nxt        = ix_r;
    status_nxt    = status_r;
    cur_sp_nxt    = cur_sp_r;
    cur_entry_nxt = cur_entry_r;
    last_err_nxt  = last_err_r;
    burst_en_nxt  = burst_en_r;
    cyc_run_nxt   = cyc_run_r;
    on_left_nxt   = on_left_r;
    off_left_nxt  = off_left_r;
    drive_nxt     = drive_r;
    carry_nxt     = carry_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    out_v_nxt     = out_v_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = ix_r;
    ram_wdata     = carry_r;
    ram_raddr     = ix_r;
    on_v          = cyc_run_r ? on_left_r : 5'(last_err_r) + ON_EXTRA;
    off_v         = cyc_run_r ? off_left_r : BURST_SPAN - 5'(last_err_r);

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_OK;
          st_nxt     = S_EXEC;
        end
      end

      // dispatch on the request kind
      S_EXEC: begin
        st_nxt = S_DONE;
        case (cmd_r)
          CMD_TICK: begin
            if (burst_en_r) begin
              cyc_run_nxt  = 1'b1;
              on_left_nxt  = on_v;
              off_left_nxt = off_v;
              if (on_v != '0) begin
                drive_nxt   = 1'b1;
                on_left_nxt = on_v - 5'd1;
              end else if (off_v != '0) begin
                drive_nxt    = 1'b0;
                off_left_nxt = off_v - 5'd1;
              end else begin
                cyc_run_nxt = 1'b0;
              end
            end
          end
          CMD_SAMPLE: begin
            if (cnt_r == '0) begin
              cur_entry_nxt = '0;
              cur_sp_nxt    = (manual_r > TEMP_MAX) ? 9'd0 : manual_r;
              st_nxt        = S_SAMPLE_FIN;
            end else begin
              ix_nxt = '0;
              st_nxt = S_SCAN_RD;
            end
          end
          CMD_INSERT: begin
            if (cnt_r == CW'(MAX_ENTRIES)) begin
              status_nxt = ST_FULL;
            end else begin
              carry_nxt = new_entry;
              cnt_nxt   = cnt_r + CW'(1);
              ix_nxt    = IW'(cnt_r);
              st_nxt    = (cnt_r == '0) ? S_SORT_END : S_SORT_RD;
            end
          end
          CMD_DELETE: begin
            if (idx_c > cnt_c) begin
              status_nxt = ST_RANGE;
            end else if (idx_c == cnt_c) begin
              cnt_nxt = '0;
            end else begin
              ix_nxt = IW'(idx_r);
              st_nxt = S_IDX_RD;
            end
          end
          CMD_EDIT: begin
            if (idx_c >= cnt_c) begin
              status_nxt = ST_RANGE;
            end else begin
              ix_nxt = IW'(idx_r);
              st_nxt = S_IDX_RD;
            end
          end
          default: begin
            st_nxt = S_DONE;
          end
        endcase
      end

      // lookup: last entry not later than now, entry 0 as fallback
      S_SCAN_RD: begin
        ram_raddr = ix_r;
        st_nxt    = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if ((ix_r == '0) || !entry_later) begin
          cur_entry_nxt = ix_r;
          cur_sp_nxt    = ram_rdata.temp;
        end
        if ((CW'(ix_r) + CW'(1)) < cnt_r) begin
          ix_nxt = ix_r + IW'(1);
          st_nxt = S_SCAN_RD;
        end else begin
          st_nxt = S_SAMPLE_FIN;
        end
      end

      // error decides forced drive on, forced drive off or burst mode
      S_SAMPLE_FIN: begin
        if ($signed(diff) > 11'sd15) begin
          drive_nxt    = 1'b1;
          burst_en_nxt = 1'b0;
          cyc_run_nxt  = 1'b0;
        end else if ($signed(diff) <= 11'sd0) begin
          drive_nxt    = 1'b0;
          burst_en_nxt = 1'b0;
          cyc_run_nxt  = 1'b0;
        end else begin
          burst_en_nxt = 1'b1;
          last_err_nxt = diff[3:0];
        end
        st_nxt = S_DONE;
      end

      // read the addressed entry for edit or delete
      S_IDX_RD: begin
        ram_raddr = ix_r;
        st_nxt    = S_IDX_WAIT;
      end

      S_IDX_WAIT: begin
        hold_nxt = ram_rdata;
        if (cmd_r == CMD_EDIT) begin
          // entry 0 keeps its time
          ram_we    = 1'b1;
          ram_waddr = ix_r;
          ram_wdata = (ix_r == '0) ? {new_entry.temp, ram_rdata.minute, ram_rdata.hour}
                                   : {new_entry.temp, mn_r > MINUTE_MAX ? 6'd0 : mn_r,
                                      hr_r > HOUR_MAX ? 5'd0 : hr_r};
          st_nxt    = S_SORT_LD;
        end else if ((CW'(ix_r) + CW'(1)) < cnt_r) begin
          st_nxt = S_DEL_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = S_DONE;
        end
      end

      // delete: shift later entries down one place
      S_DEL_RD: begin
        ram_raddr = ix_r + IW'(1);
        st_nxt    = S_DEL_WR;
      end

      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ix_r;
        ram_wdata = (ix_r == '0) ? {ram_rdata.temp, hold_r.minute, hold_r.hour}
                                 : ram_rdata;
        ix_nxt    = ix_r + IW'(1);
        if ((CW'(ix_r) + CW'(2)) < cnt_r) begin
          st_nxt = S_DEL_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = S_DONE;
        end
      end

      // sort pass from the end: load the last entry as the carry
      S_SORT_LD: begin
        ram_raddr = IW'(cnt_r - CW'(1));
        st_nxt    = S_SORT_LDW;
      end

      S_SORT_LDW: begin
        carry_nxt = ram_rdata;
        ix_nxt    = IW'(cnt_r - CW'(1));
        st_nxt    = (cnt_r == CW'(1)) ? S_SORT_END : S_SORT_RD;
      end

      S_SORT_RD: begin
        ram_raddr = ix_r - IW'(1);
        st_nxt    = S_SORT_CMP;
      end

      // later of the pair goes up, earlier one travels on as carry
      S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = ix_r;
        if (entry_later) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = carry_r;
          carry_nxt = ram_rdata;
        end
        ix_nxt = ix_r - IW'(1);
        st_nxt = (ix_r == IW'(1)) ? S_SORT_END : S_SORT_RD;
      end

      S_SORT_END: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = carry_r;
        st_nxt    = S_DONE;
      end

      // load the result once the output register is free
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt    = 1'b1;
          out_data_nxt = {3'b000, status_r, 5'(cnt_r), 4'(cur_entry_r), cur_sp_r, drive_r};
          st_nxt       = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      ix_r        <= '0;
      status_r    <= ST_OK;
      cur_sp_r    <= SP_RESET;
      cur_entry_r <= '0;
      last_err_r  <= '0;
      burst_en_r  <= 1'b0;
      cyc_run_r   <= 1'b0;
      on_left_r   <= '0;
      off_left_r  <= '0;
      drive_r     <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      ix_r        <= ix_nxt;
      status_r    <= status_nxt;
      cur_sp_r    <= cur_sp_nxt;
      cur_entry_r <= cur_entry_nxt;
      last_err_r  <= last_err_nxt;
      burst_en_r  <= burst_en_nxt;
      cyc_run_r   <= cyc_run_nxt;
      on_left_r   <= on_left_nxt;
      off_left_r  <= off_left_nxt;
      drive_r     <= drive_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  // entry count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  // one request at a time: no new request straight after one is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request taken while previous one in progress");

  // a full status is reported only with a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && status_r == ST_FULL) |-> cnt_r == CW'(MAX_ENTRIES))
    else $error("full status with room left in the table");

  // a running burst cycle implies burst mode
  a_burst_run: assert property (@(posedge clk) disable iff (!rst_n)
    cyc_run_r |-> burst_en_r)
    else $error("burst cycle running outside burst mode");

endmodule
